@@ rtl/rtcm_pkg.sv @@
// Shared types, constants and the CRC24Q byte update for the RTCM3 frame checker.
// No dependencies; every other file in rtl/ imports this package.
package rtcm_pkg;

  localparam int NUM_RELAY = 6;

  localparam logic [7:0]  PREAMBLE    = 8'hD3;
  localparam logic [23:0] CRC_POLY    = 24'h864CFB;
  localparam logic [10:0] HDR_BYTES   = 11'd3;
  localparam logic [10:0] CRC_BYTES   = 11'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_E = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_F = 3'd6;

  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic [9:0]                  max_len;
    logic [NUM_RELAY-1:0][11:0]  relay_type;
  } rtcm_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rtcm_byte_req_t;

  typedef struct packed {
    logic        in_frame;
    logic        frame_done;
    logic        frame_abort;
    logic        crc_ok;
    logic [11:0] msg_type;
    logic        relay;
    logic [10:0] frame_bytes;
    logic [31:0] frames_seen;
    logic [31:0] frames_relayed;
  } rtcm_result_t;

  // CRC24Q, MSB first, one byte per call
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/rtcm_in_stage.sv @@
// Input register of the RTCM3 frame checker: holds one received byte request.
// Depends on rtcm_pkg.
module rtcm_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              rx_byte,
  input  logic                    take,
  output rtcm_pkg::rtcm_byte_req_t req
);
  import rtcm_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       load;

  assign in_ready = !valid_q || take;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= rx_byte;
    end
  end

  assign req.valid = valid_q;
  assign req.data  = data_q;

endmodule

@@ rtl/rtcm_cfg_regs.sv @@
// Configuration registers: maximum payload length and six relay message types.
// Depends on rtcm_pkg.
module rtcm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rtcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rtcm_pkg::rtcm_cfg_t               cfg
);
  import rtcm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len    <= 10'h3FF;
      cfg.relay_type <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LEN: cfg.max_len       <= cfg_data[9:0];
        CFG_RELAY_A: cfg.relay_type[0] <= cfg_data[11:0];
        CFG_RELAY_B: cfg.relay_type[1] <= cfg_data[11:0];
        CFG_RELAY_C: cfg.relay_type[2] <= cfg_data[11:0];
        CFG_RELAY_D: cfg.relay_type[3] <= cfg_data[11:0];
        CFG_RELAY_E: cfg.relay_type[4] <= cfg_data[11:0];
        CFG_RELAY_F: cfg.relay_type[5] <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/rtcm_parser.sv @@
// Frame state, per-byte CRC24Q step, relay match, counters and the result register.
// Depends on rtcm_pkg.
module rtcm_parser #(
  parameter int MIN_FRAME_BYTES = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rtcm_pkg::rtcm_byte_req_t req,
  output logic                     take,
  input  rtcm_pkg::rtcm_cfg_t      cfg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rtcm_pkg::rtcm_result_t   res
);
  import rtcm_pkg::*;

  localparam logic [10:0] MIN_POS = 11'(MIN_FRAME_BYTES);

  logic        collecting;
  logic [10:0] byte_pos;
  logic [9:0]  payload_len;
  logic [11:0] type_reg;
  logic [23:0] crc_run;
  logic [23:0] crc_rx;
  logic [31:0] seen_count;
  logic [31:0] relayed_count;

  logic        advance;
  logic [7:0]  b;
  logic        start, active;
  logic [10:0] pos, pos_next, body;
  logic [9:0]  plen_base, plen_next;
  logic [11:0] type_base, type_next;
  logic [23:0] crc_base, crc_next, rx_base, rx_next;
  logic        feed, past_min, abort_c, done_c, ok_c, rel_c;
  logic        collecting_next;
  logic [31:0] seen_next, relayed_next;

  function automatic logic type_listed(input logic [NUM_RELAY-1:0][11:0] list,
                                       input logic [11:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RELAY; i++) begin
      if (list[i] != 12'h000 && list[i] == t) hit = 1'b1;
    end
    return hit;
  endfunction

  assign take    = !out_valid || out_ready;
  assign advance = req.valid && take;
  assign b       = req.data;

  always_comb begin
    start     = !collecting && (b == PREAMBLE);
    active    = collecting || start;
    pos       = start ? 11'd0  : byte_pos;
    plen_base = start ? 10'd0  : payload_len;
    type_base = start ? 12'd0  : type_reg;
    crc_base  = start ? 24'd0  : crc_run;
    rx_base   = start ? 24'd0  : crc_rx;

    if (pos == 11'd1)      plen_next = {b[1:0], 8'h00};
    else if (pos == 11'd2) plen_next = plen_base | {2'b00, b};
    else                   plen_next = plen_base;

    if (pos == 11'd3)      type_next = {b, 4'h0};
    else if (pos == 11'd4) type_next = type_base | {8'h00, b[7:4]};
    else                   type_next = type_base;

    body = {1'b0, plen_next} + HDR_BYTES;
    feed = (pos < HDR_BYTES) || (pos < body);
    crc_next = feed ? crc24q_byte(crc_base, b) : crc_base;
    rx_next  = feed ? rx_base : {rx_base[15:0], b};

    pos_next = pos + 11'd1;
    past_min = active && (pos_next >= MIN_POS);
    abort_c  = past_min && (plen_next > cfg.max_len);
    done_c   = past_min && !abort_c && (pos_next >= body + CRC_BYTES);
    ok_c     = done_c && (crc_next == rx_next);
    rel_c    = ok_c && type_listed(cfg.relay_type, type_next);

    collecting_next = active && !abort_c && !done_c;
    seen_next       = seen_count + {31'd0, done_c};
    relayed_next    = relayed_count + {31'd0, rel_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      byte_pos      <= '0;
      payload_len   <= '0;
      type_reg      <= '0;
      crc_run       <= '0;
      crc_rx        <= '0;
      seen_count    <= '0;
      relayed_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        collecting    <= collecting_next;
        seen_count    <= seen_next;
        relayed_count <= relayed_next;
        if (active) begin
          byte_pos    <= pos_next;
          payload_len <= plen_next;
          type_reg    <= type_next;
          crc_run     <= crc_next;
          crc_rx      <= rx_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.in_frame       <= active;
      res.frame_done     <= done_c;
      res.frame_abort    <= abort_c;
      res.crc_ok         <= ok_c;
      res.msg_type       <= done_c ? type_next : 12'd0;
      res.relay          <= rel_c;
      res.frame_bytes    <= done_c ? pos_next : 11'd0;
      res.frames_seen    <= seen_next;
      res.frames_relayed <= relayed_next;
    end
  end

`ifndef SYNTHESIS
  a_done_xor_abort: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.frame_done && res.frame_abort))
    else $error("frame_done and frame_abort set together");

  a_verdict_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.crc_ok || res.relay || res.msg_type != 12'd0)) |-> res.frame_done)
    else $error("frame verdict without frame_done");

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.frame_done) |-> (res.in_frame && res.frame_bytes >= 11'd6))
    else $error("completed frame shorter than header plus CRC");

  a_seen_count: assert property (@(posedge clk) disable iff (rst)
    advance |=> seen_count == $past(seen_count) + {31'd0, $past(done_c)})
    else $error("frame counter out of step with frame_done");

  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && (done_c || abort_c)) |=> !collecting)
    else $error("still collecting after frame end");
`endif

endmodule

@@ rtl/rtcm3_frame_checker.sv @@
// Top level of the RTCM3 frame delimiter and CRC24Q checker.
// Depends on rtcm_pkg, rtcm_in_stage, rtcm_cfg_regs and rtcm_parser.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per request.
//   Output channel (out_valid/out_ready) returns one result request per byte:
//   in_frame, frame_done, frame_abort, crc_ok, msg_type, relay, frame_bytes and
//   the running frames_seen / frames_relayed counters.
//   Config port: cfg_we with cfg_index 0 = max payload length, 1..6 = relay types
//   a..f (0 = empty entry). Other indexes are ignored. Write only while idle.
// Timing:
//   A byte accepted on the input channel lands in the input register; its result is
//   then registered in the result register and shown with out_valid high.
//   Throughput is one byte per cycle while out_ready is high, set by the
//   single-pass step between the input register and the result register
//   (byte-wide CRC24Q update and the header/length compares).
// Reset (rst, synchronous): idle, counters 0, max length 1023, relay list empty,
//   both channels empty. No clearing pass.
// Stall: with out_ready low the result holds; one more byte is still taken into
//   the input register, after which in_ready drops until the result is taken.
module rtcm3_frame_checker #(
  parameter int MIN_FRAME_BYTES = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             in_frame,
  output logic                             frame_done,
  output logic                             frame_abort,
  output logic                             crc_ok,
  output logic [11:0]                      msg_type,
  output logic                             relay,
  output logic [10:0]                      frame_bytes,
  output logic [31:0]                      frames_seen,
  output logic [31:0]                      frames_relayed,
  input  logic                             cfg_we,
  input  logic [rtcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rtcm_pkg::*;

  rtcm_byte_req_t req;
  rtcm_cfg_t      cfg;
  rtcm_result_t   res;
  logic           take;

  rtcm_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .take     (take),
    .req      (req)
  );

  rtcm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtcm_parser #(
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .take      (take),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign in_frame       = res.in_frame;
  assign frame_done     = res.frame_done;
  assign frame_abort    = res.frame_abort;
  assign crc_ok         = res.crc_ok;
  assign msg_type       = res.msg_type;
  assign relay          = res.relay;
  assign frame_bytes    = res.frame_bytes;
  assign frames_seen    = res.frames_seen;
  assign frames_relayed = res.frames_relayed;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for rtcm3_frame_checker: byte-stream stimulus (well-formed frames, noise,
// broken frames) against an in-bench frame/CRC24Q predictor. Depends on rtcm_pkg.
module testbench;
  import rtcm_pkg::*;

  localparam int MIN_FRAME = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_QUOTA = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [7:0] rx_byte;
  logic in_frame, frame_done, frame_abort, crc_ok, relay;
  logic [11:0] msg_type;
  logic [10:0] frame_bytes;
  logic [31:0] frames_seen, frames_relayed;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state and configuration
  logic        fr_active;
  logic [10:0] fr_pos;
  logic [9:0]  fr_len;
  logic [11:0] fr_type;
  logic [23:0] fr_crc, fr_crc_rx;
  logic [31:0] cnt_seen, cnt_relayed;
  logic [9:0]  cfg_max_len;
  logic [11:0] cfg_relay [NUM_RELAY];

  rtcm_result_t frame_reports_q[$];
  rtcm_result_t want;
  logic [7:0]   frame_buf[$];

  int tx_idle_pct, rx_stall_pct, hold_left;
  int framed_bytes, mismatches, idle_cycles;

  rtcm3_frame_checker #(.MIN_FRAME_BYTES(MIN_FRAME)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .in_frame(in_frame), .frame_done(frame_done), .frame_abort(frame_abort),
    .crc_ok(crc_ok), .msg_type(msg_type), .relay(relay), .frame_bytes(frame_bytes),
    .frames_seen(frames_seen), .frames_relayed(frames_relayed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bitwise CRC24Q, MSB first
  function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[23] ^ b[k];
      c = {c[22:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic rtcm_result_t frame_step(input logic [7:0] b);
    rtcm_result_t r;
    logic [10:0] pos;
    int body;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (!fr_active && b == PREAMBLE) begin
      fr_active = 1'b1;
      fr_pos = '0;
      fr_len = '0;
      fr_type = '0;
      fr_crc = '0;
      fr_crc_rx = '0;
    end
    if (fr_active) begin
      pos = fr_pos;
      r.in_frame = 1'b1;
      if (pos == 11'd1) fr_len = {b[1:0], 8'h00};
      else if (pos == 11'd2) fr_len = fr_len | {2'b00, b};
      if (pos == 11'd3) fr_type = {b, 4'h0};
      else if (pos == 11'd4) fr_type = fr_type | {8'h00, b[7:4]};
      body = int'(fr_len) + 3;
      if (int'(pos) < 3 || int'(pos) < body) fr_crc = crc24q_next(fr_crc, b);
      else fr_crc_rx = {fr_crc_rx[15:0], b};
      fr_pos = pos + 11'd1;
      if (int'(fr_pos) >= MIN_FRAME) begin
        if (fr_len > cfg_max_len) begin
          r.frame_abort = 1'b1;
          fr_active = 1'b0;
        end else if (int'(fr_pos) >= body + 3) begin
          r.frame_done = 1'b1;
          fr_active = 1'b0;
          r.crc_ok = (fr_crc == fr_crc_rx);
          r.msg_type = fr_type;
          for (int k = 0; k < NUM_RELAY; k++)
            if (cfg_relay[k] != 12'd0 && cfg_relay[k] == fr_type) hit = 1'b1;
          r.relay = r.crc_ok && hit;
          r.frame_bytes = fr_pos;
          cnt_seen = cnt_seen + 32'd1;
          if (r.relay) cnt_relayed = cnt_relayed + 32'd1;
        end
      end
    end
    r.frames_seen = cnt_seen;
    r.frames_relayed = cnt_relayed;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    rtcm_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = frame_step(b);
    frame_reports_q.push_back(r);
    if (r.in_frame) framed_bytes++;
    @(negedge clk);
  endtask

  task automatic send_buf(input int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i]);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (frame_reports_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MAX_LEN: cfg_max_len = data[9:0];
      CFG_RELAY_A, CFG_RELAY_B, CFG_RELAY_C, CFG_RELAY_D, CFG_RELAY_E, CFG_RELAY_F:
        cfg_relay[idx - CFG_RELAY_A] = data;
      default: ;
    endcase
  endtask

  // preamble, header, payload (type in the first 12 bits), CRC24Q
  task automatic build_frame(input int len, input logic [11:0] mtype, input bit bad_crc,
                             input logic [5:0] resv);
    logic [9:0] plen;
    logic [7:0] b;
    logic [23:0] crc;
    plen = len[9:0];
    crc = '0;
    frame_buf.delete();
    frame_buf.push_back(PREAMBLE);
    frame_buf.push_back({resv, plen[9:8]});
    frame_buf.push_back(plen[7:0]);
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = mtype[11:4];
      else if (i == 1) b = {mtype[3:0], 4'($urandom)};
      else b = 8'($urandom);
      frame_buf.push_back(b);
    end
    foreach (frame_buf[i]) crc = crc24q_next(crc, frame_buf[i]);
    if (bad_crc) crc = crc ^ (24'd1 << $urandom_range(23));
    frame_buf.push_back(crc[23:16]);
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // zero and one byte payloads: type comes wholly or partly from CRC bytes; 0xD3 as payload data
  task automatic test_short_payload();
    build_frame(0, 12'h000, 1'b0, 6'h00);
    send_buf(frame_buf.size());
    build_frame(1, {PREAMBLE, 4'h0}, 1'b0, 6'h15);
    send_buf(frame_buf.size());
  endtask

  task automatic test_length_abort();
    settle();
    write_reg(CFG_MAX_LEN, 12'h000);
    build_frame(1023, 12'hABC, 1'b0, 6'h3F);
    send_buf(MIN_FRAME);
  endtask

  task automatic test_max_change_mid_frame();
    settle();
    write_reg(CFG_MAX_LEN, 12'hFFF);
    build_frame(2, 12'h5A5, 1'b0, 6'h00);
    send_buf(MIN_FRAME);
    settle();
    write_reg(CFG_MAX_LEN, 12'hC01);
    send_byte(frame_buf[MIN_FRAME]);
  endtask

  // payload above 255 bytes, so the high length bits are in use
  task automatic test_long_frame();
    settle();
    write_reg(CFG_MAX_LEN, 12'h3FF);
    write_reg(CFG_RELAY_F, 12'hFFF);
    build_frame(300, 12'hFFF, 1'b0, 6'h2A);
    send_buf(frame_buf.size());
  endtask

  // output held off while the sender keeps offering bytes
  task automatic test_backpressure();
    hold_left = 200;
    for (int i = 0; i < 3; i++) begin
      build_frame($urandom_range(0, 8), cfg_relay[i], 1'b0, 6'($urandom));
      send_buf(frame_buf.size());
    end
  endtask

  task automatic test_random_phase(input int phase, input int tx_pct, input int rx_pct);
    int stop_at, pick, len, sel;
    logic [11:0] mtype;
    settle();
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    case (phase)
      0: write_reg(CFG_MAX_LEN, 12'hFFF);
      1: write_reg(CFG_MAX_LEN, 12'($urandom_range(8, 40)));
      2: begin
        write_reg(CFG_MAX_LEN, 12'h3FF);
        write_reg(CFG_UNUSED_IDX, 12'($urandom));
      end
      default: write_reg(CFG_MAX_LEN, 12'($urandom));
    endcase
    for (int k = 0; k < NUM_RELAY; k++) begin
      sel = $urandom_range(9);
      if (phase == 0 && k == 3) mtype = 12'h000;
      else if (sel < 2) mtype = 12'h000;
      else if (sel == 2) mtype = 12'hFFF;
      else mtype = 12'($urandom);
      write_reg(CFG_RELAY_A + k[CFG_IDX_W-1:0], mtype);
    end
    stop_at = framed_bytes + PHASE_QUOTA;
    while (framed_bytes < stop_at) begin
      pick = $urandom_range(99);
      sel = $urandom_range(99);
      if (sel < 50) len = $urandom_range(0, 6);
      else if (sel < 92) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 120);
      if ($urandom_range(99) < 60) mtype = cfg_relay[$urandom_range(NUM_RELAY - 1)];
      else mtype = 12'($urandom);
      if (pick < 70) begin
        build_frame(len, mtype, $urandom_range(4) == 0, 6'($urandom));
        send_buf(frame_buf.size());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        build_frame(len, mtype, 1'b0, 6'($urandom));
        send_buf($urandom_range(1, frame_buf.size() - 1));
      end
      if (phase == 0 && pick == 0) test_backpressure();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frame_reports_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = frame_reports_q.pop_front();
        if (in_frame !== want.in_frame)
          report_error($sformatf("in_frame %0d, want %0d", in_frame, want.in_frame));
        if (frame_done !== want.frame_done)
          report_error($sformatf("frame_done %0d, want %0d", frame_done, want.frame_done));
        if (frame_abort !== want.frame_abort)
          report_error($sformatf("frame_abort %0d, want %0d", frame_abort, want.frame_abort));
        if (crc_ok !== want.crc_ok)
          report_error($sformatf("crc_ok %0d, want %0d", crc_ok, want.crc_ok));
        if (msg_type !== want.msg_type)
          report_error($sformatf("msg_type %0d, want %0d", msg_type, want.msg_type));
        if (relay !== want.relay)
          report_error($sformatf("relay %0d, want %0d", relay, want.relay));
        if (frame_bytes !== want.frame_bytes)
          report_error($sformatf("frame_bytes %0d, want %0d", frame_bytes, want.frame_bytes));
        if (frames_seen !== want.frames_seen)
          report_error($sformatf("frames_seen %0d, want %0d", frames_seen, want.frames_seen));
        if (frames_relayed !== want.frames_relayed)
          report_error($sformatf("frames_relayed %0d, want %0d", frames_relayed,
                                 want.frames_relayed));
      end
    end
  end

  // watchdog: cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 0;
    framed_bytes = 0;
    mismatches = 0;
    idle_cycles = 0;
    fr_active = 1'b0;
    fr_pos = '0;
    fr_len = '0;
    fr_type = '0;
    fr_crc = '0;
    fr_crc_rx = '0;
    cnt_seen = '0;
    cnt_relayed = '0;
    cfg_max_len = 10'h3FF;
    foreach (cfg_relay[k]) cfg_relay[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ignored_bytes();
    test_short_payload();
    test_length_abort();
    test_max_change_mid_frame();
    test_long_frame();
    test_backpressure();
    test_random_phase(0, 0, 0);
    test_random_phase(1, 76, 0);
    test_random_phase(2, 0, 76);
    test_random_phase(3, 15, 15);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rtcm_pkg.sv
rtl/rtcm_in_stage.sv
rtl/rtcm_cfg_regs.sv
rtl/rtcm_parser.sv
rtl/rtcm3_frame_checker.sv
tb/testbench.sv
